### rtl/core/dtcr_pkg.sv
// dtcr_pkg: shared types and constants for the dark theme color remapper
// no dependencies
package dtcr_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned PCT_W    = 7;
  localparam int unsigned Q_W      = 17;
  localparam int unsigned T_W      = 18;

  localparam logic [CFG_IDX_W-1:0] CFG_DARK_ENABLE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUBST_COUNT = 4'd1;
  localparam int unsigned          CFG_PAIR_BASE   = 2;

  // divider geometry
  localparam int unsigned DIV_Q  = 9;
  localparam int unsigned SN_W   = 15;
  localparam int unsigned SD_W   = 9;
  localparam int unsigned HN_W   = 17;
  localparam int unsigned HD_W   = 8;

  // reciprocal multipliers for constant divides
  localparam logic [15:0] L_M    = 16'd51410;     // sum*100/510, shift 18
  localparam logic [21:0] LQ_M   = 22'd2684355;   // pct*65536/100, shift 12
  localparam logic [22:0] HQ_M   = 23'd5965233;   // deg*65536/360, shift 15
  localparam logic [18:0] BYTE_M = 19'd334254;    // pct*255/100, shift 17

  localparam logic [Q_W-1:0] Q_ONE       = 17'd65536;
  localparam logic [Q_W-1:0] Q_THIRD     = 17'd21845;
  localparam logic [Q_W-1:0] Q_TWOTHIRDS = 17'd43690;
  localparam logic [PCT_W-1:0] PCT_MAX   = 7'd100;
  localparam logic [PCT_W-1:0] PCT_HALF  = 7'd50;

  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_SUBST,
    KIND_CALC
  } kind_t;

  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_HIGH,
    SEG_FALL,
    SEG_LOW
  } seg_t;

  typedef struct packed {
    kind_t             kind;
    logic [WORD_W-1:0] word;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef struct packed {
    kind_t             kind;
    logic [WORD_W-1:0] word;
    logic [PCT_W-1:0]  lneg;
  } side_t;

endpackage

### rtl/core/dtcr_front.sv
// dtcr_front: configuration registers and item classification
// depends on dtcr_pkg
module dtcr_front #(
  parameter int unsigned SUBST_ENTRIES = 3
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we_i,
  input  logic [dtcr_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [dtcr_pkg::WORD_W-1:0]        cfg_data_i,
  input  logic [dtcr_pkg::WORD_W-1:0]        pixel_i,
  output dtcr_pkg::item_t                    item_o
);

  logic                        dark_enable_r;
  logic [1:0]                  subst_count_r;
  logic [dtcr_pkg::WORD_W-1:0] from_r [SUBST_ENTRIES];
  logic [dtcr_pkg::WORD_W-1:0] to_r   [SUBST_ENTRIES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dark_enable_r <= 1'b0;
      subst_count_r <= 2'd0;
      for (int k = 0; k < SUBST_ENTRIES; k++) begin
        from_r[k] <= '0;
        to_r[k]   <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_index_i == dtcr_pkg::CFG_DARK_ENABLE) begin
        dark_enable_r <= cfg_data_i[0];
      end
      if (cfg_index_i == dtcr_pkg::CFG_SUBST_COUNT) begin
        subst_count_r <= cfg_data_i[1:0];
      end
      for (int k = 0; k < SUBST_ENTRIES; k++) begin
        if (cfg_index_i == dtcr_pkg::CFG_IDX_W'(dtcr_pkg::CFG_PAIR_BASE + 2*k)) begin
          from_r[k] <= cfg_data_i;
        end
        if (cfg_index_i == dtcr_pkg::CFG_IDX_W'(dtcr_pkg::CFG_PAIR_BASE + 2*k + 1)) begin
          to_r[k] <= cfg_data_i;
        end
      end
    end
  end

  always_comb begin
    item_o.kind = dtcr_pkg::KIND_CALC;
    item_o.word = pixel_i;
    for (int k = SUBST_ENTRIES - 1; k >= 0; k--) begin
      if ((32'(subst_count_r) > 32'(k)) && (from_r[k] == pixel_i)) begin
        item_o.kind = dtcr_pkg::KIND_SUBST;
        item_o.word = to_r[k];
      end
    end
    if (!dark_enable_r) begin
      item_o.kind = dtcr_pkg::KIND_PASS;
      item_o.word = pixel_i;
    end
  end

endmodule

### rtl/core/dtcr_queue.sv
// dtcr_queue: two-entry queue between classification and conversion
// depends on dtcr_pkg
module dtcr_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_i,
  input  dtcr_pkg::item_t     item_i,
  input  logic                pop_i,
  output dtcr_pkg::item_t     item_o,
  output dtcr_pkg::q_stat_t   stat_o
);

  dtcr_pkg::item_t mem_r [2];
  logic            wr_ptr_r, rd_ptr_r;
  logic [1:0]      count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_r <= ~wr_ptr_r;
      if (pop_i)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) mem_r[wr_ptr_r] <= item_i;
  end

  assign item_o       = mem_r[rd_ptr_r];
  assign stat_o.empty = (count_r == 2'd0);
  assign stat_o.full  = count_r[1];

endmodule

### rtl/core/dtcr_div.sv
// dtcr_div: pipelined restoring divider, one quotient bit per stage
// depends on nothing
module dtcr_div #(
  parameter int unsigned NW = 17,
  parameter int unsigned DW = 8,
  parameter int unsigned QW = 9
) (
  input  logic          clk,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  localparam int unsigned WW = DW + QW;

  logic [WW-1:0] rem_r [QW];
  logic [QW-1:0] q_r   [QW];
  logic [DW-1:0] den_r [QW-1];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [WW-1:0] rem_src;
    logic [QW-1:0] q_src;
    logic [DW-1:0] den_src;
    logic [WW-1:0] trial;
    logic          ge;

    if (i == 0) begin : g_first
      assign rem_src = WW'(num_i);
      assign q_src   = '0;
      assign den_src = den_i;
    end else begin : g_next
      assign rem_src = rem_r[i-1];
      assign q_src   = q_r[i-1];
      assign den_src = den_r[i-1];
    end

    assign trial = WW'(den_src) << (QW - 1 - i);
    assign ge    = (rem_src >= trial);

    always_ff @(posedge clk) begin
      rem_r[i] <= ge ? (rem_src - trial) : rem_src;
      q_r[i]   <= {q_src[QW-2:0], ge};
    end

    if (i < QW - 1) begin : g_den
      always_ff @(posedge clk) begin
        den_r[i] <= den_src;
      end
    end
  end

  assign quo_o = q_r[QW-1];

endmodule

### rtl/core/dtcr_back.sv
// dtcr_back: hsl lightness inversion pipeline and result register
// depends on dtcr_pkg, dtcr_div
module dtcr_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        vld_i,
  input  dtcr_pkg::item_t             item_i,
  output logic                        out_valid_o,
  output logic [dtcr_pkg::WORD_W-1:0] out_color_o,
  output logic                        out_subst_o
);

  localparam int unsigned QW = dtcr_pkg::Q_W;
  localparam int unsigned TW = dtcr_pkg::T_W;
  localparam int unsigned PW = dtcr_pkg::PCT_W;
  localparam int unsigned DQ = dtcr_pkg::DIV_Q;

  // stage b0: channel extremes, divider operands, lightness
  logic [7:0] r_c, g_c, b_c, mx_c, mn_c, d_c;
  logic [8:0] sum_c, den_c;
  logic [dtcr_pkg::HN_W-1:0] hnum_c;
  logic [24:0] lprod_c;
  logic [PW-1:0] l_c;

  always_comb begin
    r_c = item_i.word[7:0];
    g_c = item_i.word[15:8];
    b_c = item_i.word[23:16];
    mx_c = r_c;
    mn_c = r_c;
    if (g_c > mx_c) mx_c = g_c;
    if (b_c > mx_c) mx_c = b_c;
    if (g_c < mn_c) mn_c = g_c;
    if (b_c < mn_c) mn_c = b_c;
    d_c   = mx_c - mn_c;
    sum_c = 9'(mx_c) + 9'(mn_c);
    den_c = (sum_c < 9'd255) ? sum_c : (9'd510 - sum_c);
    if (d_c == 8'd0) den_c = 9'd1;
    priority if (d_c == 8'd0) begin
      hnum_c = '0;
    end else if (b_c == mx_c) begin
      hnum_c = 17'd240 * 17'(d_c) + 17'd60 * 17'(r_c) - 17'd60 * 17'(g_c);
    end else if (g_c == mx_c) begin
      hnum_c = 17'd120 * 17'(d_c) + 17'd60 * 17'(b_c) - 17'd60 * 17'(r_c);
    end else if (g_c >= b_c) begin
      hnum_c = 17'd60 * 17'(g_c - b_c);
    end else begin
      hnum_c = 17'd360 * 17'(d_c) - 17'd60 * 17'(b_c - g_c);
    end
    lprod_c = 25'(sum_c) * 25'(dtcr_pkg::L_M);
    l_c     = PW'(lprod_c >> 18);
  end

  logic                         b0_vld_r;
  dtcr_pkg::side_t              b0_side_r;
  logic [dtcr_pkg::SN_W-1:0]    b0_snum_r;
  logic [dtcr_pkg::SD_W-1:0]    b0_sden_r;
  logic [dtcr_pkg::HN_W-1:0]    b0_hnum_r;
  logic [dtcr_pkg::HD_W-1:0]    b0_hden_r;

  always_ff @(posedge clk) begin
    b0_side_r.kind <= item_i.kind;
    b0_side_r.word <= item_i.word;
    b0_side_r.lneg <= dtcr_pkg::PCT_MAX - l_c;
    b0_snum_r      <= 15'd100 * 15'(d_c);
    b0_sden_r      <= den_c;
    b0_hnum_r      <= hnum_c;
    b0_hden_r      <= (d_c == 8'd0) ? 8'd1 : d_c;
  end

  // saturation and hue dividers
  logic [DQ-1:0] s_quo, h_quo;

  dtcr_div #(.NW(dtcr_pkg::SN_W), .DW(dtcr_pkg::SD_W), .QW(DQ)) u_div_s (
    .clk  (clk),
    .num_i(b0_snum_r),
    .den_i(b0_sden_r),
    .quo_o(s_quo)
  );

  dtcr_div #(.NW(dtcr_pkg::HN_W), .DW(dtcr_pkg::HD_W), .QW(DQ)) u_div_h (
    .clk  (clk),
    .num_i(b0_hnum_r),
    .den_i(b0_hden_r),
    .quo_o(h_quo)
  );

  dtcr_pkg::side_t side_r [DQ];

  always_ff @(posedge clk) begin
    side_r[0] <= b0_side_r;
    for (int i = 1; i < DQ; i++) side_r[i] <= side_r[i-1];
  end

  // valid line: b0, divider stages, s1..s6
  localparam int unsigned VL = DQ + 7;
  logic [VL-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[VL-2:0], vld_i};
    end
  end
  assign b0_vld_r = vld_r[0];

  // s1: fixed point operands
  logic [PW-1:0] s_c;
  logic [28:0]   lqp_c, sqp_c;
  logic [31:0]   hqp_c;

  always_comb begin
    s_c   = (s_quo > 9'd100) ? dtcr_pkg::PCT_MAX : PW'(s_quo);
    lqp_c = 29'(side_r[DQ-1].lneg) * 29'(dtcr_pkg::LQ_M);
    sqp_c = 29'(s_c) * 29'(dtcr_pkg::LQ_M);
    hqp_c = 32'(h_quo) * 32'(dtcr_pkg::HQ_M);
  end

  dtcr_pkg::side_t s1_side_r;
  logic [QW-1:0]   s1_lq_r, s1_sq_r, s1_hq_r;
  logic            s1_szero_r;

  always_ff @(posedge clk) begin
    s1_side_r  <= side_r[DQ-1];
    s1_lq_r    <= QW'(lqp_c >> 12);
    s1_sq_r    <= QW'(sqp_c >> 12);
    s1_hq_r    <= QW'(hqp_c >> 15);
    s1_szero_r <= (s_c == '0);
  end

  // s2: products for t1
  dtcr_pkg::side_t s2_side_r;
  logic [QW-1:0]   s2_lq_r, s2_sq_r, s2_hq_r;
  logic            s2_szero_r;
  logic [35:0]     s2_pa_r;
  logic [33:0]     s2_pb_r;

  always_ff @(posedge clk) begin
    s2_side_r  <= s1_side_r;
    s2_lq_r    <= s1_lq_r;
    s2_sq_r    <= s1_sq_r;
    s2_hq_r    <= s1_hq_r;
    s2_szero_r <= s1_szero_r;
    s2_pa_r    <= 36'(s1_lq_r) * (36'(dtcr_pkg::Q_ONE) + 36'(s1_sq_r));
    s2_pb_r    <= 34'(s1_lq_r) * 34'(s1_sq_r);
  end

  // s3: t1, t2 and channel arguments
  logic [TW-1:0]       t1_c;
  logic signed [19:0]  t2s_c;
  logic [TW-1:0]       t2_c;
  logic [QW:0]         tr_c;
  logic signed [18:0]  tbs_c;
  logic [QW-1:0]       tb_c;

  always_comb begin
    if (s2_side_r.lneg < dtcr_pkg::PCT_HALF) begin
      t1_c = TW'(s2_pa_r >> 16);
    end else begin
      t1_c = TW'(s2_lq_r) + TW'(s2_sq_r) - TW'(s2_pb_r >> 16);
    end
    t2s_c = 20'sd2 * signed'(20'(s2_lq_r)) - signed'(20'(t1_c));
    t2_c  = (t2s_c < 0) ? '0 : TW'(t2s_c);
    tr_c  = 18'(s2_hq_r) + 18'(dtcr_pkg::Q_THIRD);
    if (tr_c > 18'(dtcr_pkg::Q_ONE)) tr_c = tr_c - 18'(dtcr_pkg::Q_ONE);
    tbs_c = signed'(19'(s2_hq_r)) - signed'(19'(dtcr_pkg::Q_THIRD));
    if (tbs_c < 0) tbs_c = tbs_c + signed'(19'(dtcr_pkg::Q_ONE));
    tb_c  = QW'(tbs_c);
  end

  dtcr_pkg::side_t s3_side_r;
  logic            s3_szero_r;
  logic [TW-1:0]   s3_t1_r, s3_t2_r;
  logic [QW-1:0]   s3_t_r [3];

  always_ff @(posedge clk) begin
    s3_side_r  <= s2_side_r;
    s3_szero_r <= s2_szero_r;
    s3_t1_r    <= t1_c;
    s3_t2_r    <= t2_c;
    s3_t_r[0]  <= QW'(tr_c);
    s3_t_r[1]  <= s2_hq_r;
    s3_t_r[2]  <= tb_c;
  end

  // s4: segment select and slope product per channel
  dtcr_pkg::seg_t seg_c [3];
  logic [15:0]    m_c   [3];
  logic [TW-1:0]  diff_c;

  always_comb begin
    diff_c = s3_t1_r - s3_t2_r;
    for (int c = 0; c < 3; c++) begin
      m_c[c] = '0;
      priority if (20'(s3_t_r[c]) * 20'd6 < 20'(dtcr_pkg::Q_ONE)) begin
        seg_c[c] = dtcr_pkg::SEG_RISE;
        m_c[c]   = 16'(20'(s3_t_r[c]) * 20'd6);
      end else if (20'(s3_t_r[c]) * 20'd2 < 20'(dtcr_pkg::Q_ONE)) begin
        seg_c[c] = dtcr_pkg::SEG_HIGH;
      end else if (20'(s3_t_r[c]) * 20'd3 < 20'd131072) begin
        seg_c[c] = dtcr_pkg::SEG_FALL;
        m_c[c]   = 16'((20'(dtcr_pkg::Q_TWOTHIRDS) - 20'(s3_t_r[c])) * 20'd6);
      end else begin
        seg_c[c] = dtcr_pkg::SEG_LOW;
      end
    end
  end

  dtcr_pkg::side_t s4_side_r;
  logic            s4_szero_r;
  logic [TW-1:0]   s4_t1_r, s4_t2_r;
  dtcr_pkg::seg_t  s4_seg_r [3];
  logic [33:0]     s4_p_r   [3];

  always_ff @(posedge clk) begin
    s4_side_r  <= s3_side_r;
    s4_szero_r <= s3_szero_r;
    s4_t1_r    <= s3_t1_r;
    s4_t2_r    <= s3_t2_r;
    for (int c = 0; c < 3; c++) begin
      s4_seg_r[c] <= seg_c[c];
      s4_p_r[c]   <= 34'(diff_c) * 34'(m_c[c]);
    end
  end

  // s5: channel percent
  logic [35:0]   x_c   [3];
  logic [42:0]   xp_c  [3];
  logic [10:0]   v_c   [3];
  logic [PW-1:0] pct_c [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      unique case (s4_seg_r[c])
        dtcr_pkg::SEG_HIGH: x_c[c] = 36'(s4_t1_r) << 16;
        dtcr_pkg::SEG_LOW:  x_c[c] = 36'(s4_t2_r) << 16;
        default:            x_c[c] = (36'(s4_t2_r) << 16) + 36'(s4_p_r[c]);
      endcase
      xp_c[c]  = 43'(x_c[c]) * 43'd100;
      v_c[c]   = 11'(xp_c[c] >> 32);
      pct_c[c] = (v_c[c] > 11'd100) ? dtcr_pkg::PCT_MAX : PW'(v_c[c]);
      if (s4_szero_r) pct_c[c] = s4_side_r.lneg;
    end
  end

  dtcr_pkg::side_t s5_side_r;
  logic [PW-1:0]   s5_pct_r [3];

  always_ff @(posedge clk) begin
    s5_side_r <= s4_side_r;
    for (int c = 0; c < 3; c++) s5_pct_r[c] <= pct_c[c];
  end

  // s6: bytes and result register
  logic [25:0] byp_c  [3];
  logic [7:0]  byte_c [3];
  logic [dtcr_pkg::WORD_W-1:0] color_c;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      byp_c[c]  = 26'(s5_pct_r[c]) * 26'(dtcr_pkg::BYTE_M);
      byte_c[c] = 8'(byp_c[c] >> 17);
    end
    unique case (s5_side_r.kind)
      dtcr_pkg::KIND_CALC: color_c = {8'd0, byte_c[2], byte_c[1], byte_c[0]};
      default:             color_c = s5_side_r.word;
    endcase
  end

  always_ff @(posedge clk) begin
    out_color_o <= color_c;
    out_subst_o <= (s5_side_r.kind == dtcr_pkg::KIND_SUBST);
  end

  assign out_valid_o = vld_r[VL-1] & b0_vld_r | vld_r[VL-1];

endmodule

### rtl/core/dark_theme_color_remap.sv
// dark_theme_color_remap: top level of the dark theme color remapper
// depends on dtcr_pkg, dtcr_front, dtcr_queue, dtcr_back, dtcr_div
//
// channel  ports                                         beat taken when
// in       start, busy, in_pixel_color                   start & !busy
// out      out_valid, out_result_color,                  every out_valid cycle
//          out_was_substituted
// cfg      cfg_valid, cfg_ready, cfg_index, cfg_data     cfg_valid & cfg_ready
//
// one beat per clock sustained; each result is registered through the queue,
// the 9-stage saturation and hue dividers and 7 stages of fixed point
// conversion. the back pipeline never stalls, so the two-entry queue never
// fills and busy stays low after reset. synchronous reset clears the
// registers, the queue and all valid bits. results last one cycle each.
module dark_theme_color_remap #(
  parameter int unsigned SUBST_ENTRIES = 3
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [dtcr_pkg::WORD_W-1:0]          in_pixel_color,
  output logic                                 out_valid,
  output logic [dtcr_pkg::WORD_W-1:0]          out_result_color,
  output logic                                 out_was_substituted,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [dtcr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dtcr_pkg::WORD_W-1:0]          cfg_data
);

  dtcr_pkg::item_t   front_item, head_item;
  dtcr_pkg::q_stat_t q_stat;
  logic              push, pop;

  assign cfg_ready = 1'b1;
  assign busy      = q_stat.full;
  assign push      = start & ~q_stat.full;
  assign pop       = ~q_stat.empty;

  dtcr_front #(.SUBST_ENTRIES(SUBST_ENTRIES)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we_i   (cfg_valid & cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .pixel_i    (in_pixel_color),
    .item_o     (front_item)
  );

  dtcr_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push_i(push),
    .item_i(front_item),
    .pop_i (pop),
    .item_o(head_item),
    .stat_o(q_stat)
  );

  dtcr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .vld_i      (pop),
    .item_i     (head_item),
    .out_valid_o(out_valid),
    .out_color_o(out_result_color),
    .out_subst_o(out_was_substituted)
  );

endmodule

### sim/testbench.sv
// testbench for dark_theme_color_remap: directed table, then randomized pixel beats
// checked against an in-bench lightness inversion and substitution predictor
// depends on dtcr_pkg and the dark_theme_color_remap rtl
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned PAIRS        = 3;
  localparam int unsigned LATENCY      = 16;
  localparam int unsigned LIMIT        = 300000;
  localparam logic [dtcr_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LO = 4'd8;
  localparam longint QONE   = 65536;
  localparam longint QTHIRD = 21845;
  localparam longint QTWO3  = 43690;

  typedef struct {
    logic [dtcr_pkg::WORD_W-1:0] color;
    logic                        substituted;
  } remap_t;

  typedef struct {
    logic [dtcr_pkg::WORD_W-1:0] pixel;
    logic                        typed;
    logic [dtcr_pkg::WORD_W-1:0] color;
    logic                        substituted;
  } vector_t;

  logic                           clk;
  logic                           rst_n;
  logic                           start;
  logic                           busy;
  logic [dtcr_pkg::WORD_W-1:0]    in_pixel_color;
  logic                           out_valid;
  logic [dtcr_pkg::WORD_W-1:0]    out_result_color;
  logic                           out_was_substituted;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [dtcr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [dtcr_pkg::WORD_W-1:0]    cfg_data;

  logic                        dark_on;
  logic [1:0]                  pair_count;
  logic [dtcr_pkg::WORD_W-1:0] match_word [PAIRS];
  logic [dtcr_pkg::WORD_W-1:0] swap_word [PAIRS];

  remap_t      pending_colors[$];
  int unsigned errors;
  int unsigned cycles;
  int unsigned idle_pct;

  dark_theme_color_remap #(.SUBST_ENTRIES(PAIRS)) i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_pixel_color      (in_pixel_color),
    .out_valid           (out_valid),
    .out_result_color    (out_result_color),
    .out_was_substituted (out_was_substituted),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic longint pct_clamp(longint v);
    if (v < 0) return 0;
    if (v > 100) return 100;
    return v;
  endfunction

  function automatic longint segment_pct(longint t1, longint t2, longint t);
    longint v;
    if (t * 6 < QONE)
      v = ((t2 * QONE + (t1 - t2) * 6 * t) * 100) >>> 32;
    else if (t * 2 < QONE)
      v = (t1 * 100) >>> 16;
    else if (t * 3 < 2 * QONE)
      v = ((t2 * QONE + (t1 - t2) * (QTWO3 - t) * 6) * 100) >>> 32;
    else
      v = (t2 * 100) >>> 16;
    return pct_clamp(v);
  endfunction

  function automatic logic [dtcr_pkg::WORD_W-1:0] invert_lightness(
      logic [dtcr_pkg::WORD_W-1:0] w);
    longint r, g, b, mx, mn, d, h, s, l, den, cr, cg, cb;
    longint lq, sq, hq, t1, t2, tr, tb;
    r = w[7:0];
    g = w[15:8];
    b = w[23:16];
    mx = r;
    mn = r;
    h = 0;
    s = 0;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    l = (100 * (mx + mn)) / 510;
    if (d != 0) begin
      den = (mx + mn < 255) ? (mx + mn) : (510 - mx - mn);
      s = (100 * d) / den;
      if (b == mx) h = (240 * d + 60 * (r - g)) / d;
      else if (g == mx) h = (120 * d + 60 * (b - r)) / d;
      else if (g >= b) h = (60 * (g - b)) / d;
      else h = (360 * d - 60 * (b - g)) / d;
    end
    l = pct_clamp(100 - l);
    s = pct_clamp(s);
    if (s == 0) begin
      cr = l;
      cg = l;
      cb = l;
    end else begin
      lq = (l * QONE) / 100;
      sq = (s * QONE) / 100;
      hq = (h * QONE) / 360;
      if (l < 50) t1 = (lq * (QONE + sq)) >>> 16;
      else t1 = lq + sq - ((lq * sq) >>> 16);
      t2 = 2 * lq - t1;
      if (t2 < 0) t2 = 0;
      tr = hq + QTHIRD;
      if (tr > QONE) tr -= QONE;
      tb = hq - QTHIRD;
      if (tb < 0) tb += QONE;
      cr = segment_pct(t1, t2, tr);
      cg = segment_pct(t1, t2, hq);
      cb = segment_pct(t1, t2, tb);
    end
    cr = (cr * 255) / 100;
    cg = (cg * 255) / 100;
    cb = (cb * 255) / 100;
    return {8'h00, cb[7:0], cg[7:0], cr[7:0]};
  endfunction

  function automatic remap_t predict_remap(logic [dtcr_pkg::WORD_W-1:0] w);
    remap_t res;
    int n;
    res.color = w;
    res.substituted = 1'b0;
    if (!dark_on) return res;
    n = (pair_count > PAIRS) ? PAIRS : pair_count;
    for (int i = 0; i < n; i++) begin
      if (match_word[i] == w) begin
        res.color = swap_word[i];
        res.substituted = 1'b1;
        return res;
      end
    end
    res.color = invert_lightness(w);
    return res;
  endfunction

  always @(posedge clk) begin
    remap_t exp_r;
    if (rst_n && out_valid) begin
      if (pending_colors.size() == 0) begin
        $error("unexpected result beat color=%h", out_result_color);
        errors++;
      end else begin
        exp_r = pending_colors.pop_front();
        if (out_result_color !== exp_r.color) begin
          $error("result_color expected %h actual %h", exp_r.color, out_result_color);
          errors++;
        end
        if (out_was_substituted !== exp_r.substituted) begin
          $error("was_substituted expected %b actual %b", exp_r.substituted,
                 out_was_substituted);
          errors++;
        end
      end
    end
  end

  task automatic send_pixel(logic [dtcr_pkg::WORD_W-1:0] w, remap_t exp_r);
    @(negedge clk);
    start <= 1'b1;
    in_pixel_color <= w;
    while (busy) @(negedge clk);
    @(posedge clk);
    pending_colors.push_back(exp_r);
  endtask

  task automatic maybe_idle();
    if ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      in_pixel_color <= $urandom;
      repeat ($urandom_range(3)) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(logic [dtcr_pkg::CFG_IDX_W-1:0] idx,
                           logic [dtcr_pkg::WORD_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    if (idx == dtcr_pkg::CFG_DARK_ENABLE) dark_on = data[0];
    else if (idx == dtcr_pkg::CFG_SUBST_COUNT) pair_count = data[1:0];
    else if (idx < CFG_UNUSED_LO) begin
      if (idx[0] == 1'b0) match_word[2'((idx - dtcr_pkg::CFG_PAIR_BASE) >> 1)] = data;
      else swap_word[2'((idx - dtcr_pkg::CFG_PAIR_BASE) >> 1)] = data;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_pair(int k, logic [dtcr_pkg::WORD_W-1:0] from_w,
                            logic [dtcr_pkg::WORD_W-1:0] to_w);
    write_reg(dtcr_pkg::CFG_IDX_W'(dtcr_pkg::CFG_PAIR_BASE + 2 * k), from_w);
    write_reg(dtcr_pkg::CFG_IDX_W'(dtcr_pkg::CFG_PAIR_BASE + 2 * k + 1), to_w);
  endtask

  task automatic run_table(const ref vector_t tbl[]);
    remap_t exp_r;
    foreach (tbl[i]) begin
      if (tbl[i].typed) begin
        exp_r.color = tbl[i].color;
        exp_r.substituted = tbl[i].substituted;
      end else begin
        exp_r = predict_remap(tbl[i].pixel);
      end
      send_pixel(tbl[i].pixel, exp_r);
    end
    drain();
  endtask

  function automatic logic [dtcr_pkg::WORD_W-1:0] pick_pixel();
    logic [dtcr_pkg::WORD_W-1:0] w;
    int sel;
    sel = $urandom_range(99);
    w = $urandom;
    if (sel < 20) begin
      w = match_word[$urandom_range(PAIRS - 1)];
    end else if (sel < 35) begin
      w[23:16] = w[7:0];
      w[15:8] = w[7:0];
    end else if (sel < 50) begin
      w[7:0] = $urandom_range(1) ? 8'hff : 8'h00;
      w[15:8] = $urandom_range(1) ? 8'hff : w[7:0];
    end
    return w;
  endfunction

  vector_t pass_rows[];
  vector_t dark_rows[];

  initial begin
    logic [dtcr_pkg::WORD_W-1:0] w;
    start = 1'b0;
    in_pixel_color = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rst_n = 1'b0;
    idle_pct = 0;
    dark_on = 1'b0;
    pair_count = '0;
    for (int i = 0; i < PAIRS; i++) begin
      match_word[i] = '0;
      swap_word[i] = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // after reset remapping is off
    pass_rows = '{
      '{32'h00000000, 1'b1, 32'h00000000, 1'b0},
      '{32'hffffffff, 1'b1, 32'hffffffff, 1'b0},
      '{32'h12345678, 1'b1, 32'h12345678, 1'b0},
      '{32'hedcba987, 1'b1, 32'hedcba987, 1'b0}
    };
    run_table(pass_rows);

    write_reg(dtcr_pkg::CFG_DARK_ENABLE, 32'hffffffff);
    write_reg(dtcr_pkg::CFG_SUBST_COUNT, 32'hffffffff);
    write_pair(0, 32'hffffffff, 32'h00000000);
    write_pair(1, 32'h11223344, 32'hffffffff);
    write_pair(2, 32'h11223344, 32'h55667788);
    write_reg(CFG_UNUSED_LO, 32'h00000000);
    write_reg(4'hf, 32'hffffffff);
    dark_rows = '{
      '{32'hffffffff, 1'b1, 32'h00000000, 1'b1},
      '{32'h11223344, 1'b1, 32'hffffffff, 1'b1},
      '{32'h00ffffff, 1'b1, 32'h00000000, 1'b0},
      '{32'hff000000, 1'b1, 32'h00ffffff, 1'b0},
      '{32'h00000000, 1'b1, 32'h00ffffff, 1'b0},
      '{32'h010000ff, 1'b0, 32'h0, 1'b0},
      '{32'h0000ff00, 1'b0, 32'h0, 1'b0},
      '{32'h00ff0000, 1'b0, 32'h0, 1'b0},
      '{32'h0000ffff, 1'b0, 32'h0, 1'b0},
      '{32'h00ff00ff, 1'b0, 32'h0, 1'b0},
      '{32'h00ffff00, 1'b0, 32'h0, 1'b0},
      '{32'h00808080, 1'b0, 32'h0, 1'b0},
      '{32'h00102030, 1'b0, 32'h0, 1'b0},
      '{32'h00302010, 1'b0, 32'h0, 1'b0},
      '{32'h7f7fff7f, 1'b0, 32'h0, 1'b0},
      '{32'h11223345, 1'b0, 32'h0, 1'b0}
    };
    run_table(dark_rows);

    // random phases, each with a fresh register setting
    for (int ph = 0; ph < 8; ph++) begin
      idle_pct = (ph < 3) ? 12 : (ph < 6) ? 47 : 0;
      w = $urandom;
      w[0] = ($urandom_range(9) != 0);
      write_reg(dtcr_pkg::CFG_DARK_ENABLE, w);
      write_reg(dtcr_pkg::CFG_SUBST_COUNT, $urandom);
      for (int k = 0; k < PAIRS; k++) write_pair(k, $urandom, $urandom);
      write_reg(dtcr_pkg::CFG_IDX_W'($urandom_range(15, CFG_UNUSED_LO)), $urandom);
      for (int n = 0; n < 50; n++) begin
        w = pick_pixel();
        send_pixel(w, predict_remap(w));
        maybe_idle();
      end
      drain();
    end

    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
